FILE: src/pcc_pkg.sv
// Shared constants and lane control types for the correlation threshold block.
package pcc_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_LENGTH_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths of the channels.
    localparam int FIELD_BITS = 16;
    localparam int THR_BITS   = 16;

    // Threshold after reset, 0.9 in unsigned Q0.16.
    localparam logic [THR_BITS-1:0] THR_RESET = 16'd58982;

    // Digit width of the iterative multipliers (one digit by one digit per cycle).
    localparam int MUL_DIGIT = 32;

    // Commands from the top level to one lane.
    typedef struct packed {
        logic start;
        logic take;
    } t_lane_ctl;

    // Status of one lane.
    typedef struct packed {
        logic idle;
        logic done;
    } t_lane_stat;

endpackage

FILE: src/pcc_if.sv
// Valid/ready channel interfaces for the sample, configuration and result streams.
interface pcc_in_if;
    logic                            valid;
    logic                            ready;
    logic [pcc_pkg::FIELD_BITS-1:0]  x_sample;
    logic [pcc_pkg::FIELD_BITS-1:0]  y_sample;
    logic                            last;

    modport source (output valid, output x_sample, output y_sample, output last,
                    input ready);
    modport sink   (input valid, input x_sample, input y_sample, input last,
                    output ready);
endinterface

interface pcc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pcc_pkg::THR_BITS-1:0]  threshold_q16;

    modport source (output valid, output threshold_q16, input ready);
    modport sink   (input valid, input threshold_q16, output ready);
endinterface

interface pcc_out_if;
    logic valid;
    logic ready;
    logic linked;
    logic degenerate;

    modport source (output valid, output linked, output degenerate, input ready);
    modport sink   (input valid, input linked, input degenerate, output ready);
endinterface

FILE: src/pcc_mul.sv
// Iterative wide multiplier: one digit-by-digit partial product per cycle.
module pcc_mul #(
    parameter int WA = pcc_pkg::MUL_DIGIT,
    parameter int WB = pcc_pkg::MUL_DIGIT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WA-1:0]    i_a,
    input  logic [WB-1:0]    i_b,
    output logic             o_done,
    output logic [WA+WB-1:0] o_p
);

    localparam int D    = pcc_pkg::MUL_DIGIT;
    localparam int NA   = (WA + D - 1) / D;
    localparam int NB   = (WB + D - 1) / D;
    localparam int ABW  = NA * D;
    localparam int BBW  = NB * D;
    localparam int AW   = ABW + BBW;
    localparam int PPW  = 2 * D;
    localparam int IA   = (NA > 1) ? $clog2(NA) : 1;
    localparam int IB   = (NB > 1) ? $clog2(NB) : 1;
    localparam int KW   = $clog2(NA + NB);

    logic [NA-1:0][D-1:0] r_a;
    logic [NB-1:0][D-1:0] r_b;
    logic [IA-1:0]        r_i;
    logic [IB-1:0]        r_j;
    logic                 r_run;
    logic [PPW-1:0]       r_pp;
    logic [KW-1:0]        r_k;
    logic                 r_pp_valid;
    logic                 r_pp_last;
    logic [AW-1:0]        r_acc;
    logic                 r_done;
    logic                 last_pair;

    assign last_pair = (r_i == IA'(NA - 1)) && (r_j == IB'(NB - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b0;
            r_pp_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done     <= r_pp_valid && r_pp_last;
            r_pp_valid <= r_run;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && last_pair) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= ABW'(i_a);
            r_b   <= BBW'(i_b);
            r_i   <= '0;
            r_j   <= '0;
            r_acc <= '0;
        end else begin
            if (r_run) begin
                r_pp      <= PPW'(r_a[r_i]) * PPW'(r_b[r_j]);
                r_k       <= KW'(r_i) + KW'(r_j);
                r_pp_last <= last_pair;
                if (!last_pair) begin
                    if (r_j == IB'(NB - 1)) begin
                        r_j <= '0;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
            end
            if (r_pp_valid) begin
                r_acc <= r_acc + (AW'(r_pp) << (r_k * D));
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc[WA+WB-1:0];

    // A new product may only be started once the previous one has fully drained.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (!r_run && !r_pp_valid))
        else $error("multiplier started while busy");

endmodule

FILE: src/pcc_lane.sv
// One lane: forms u*v - w*w2 with a shared multiplier, clipped at zero.
module pcc_lane #(
    parameter int WA = pcc_pkg::MUL_DIGIT,
    parameter int WB = pcc_pkg::MUL_DIGIT,
    parameter int PW = pcc_pkg::MUL_DIGIT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcc_pkg::t_lane_ctl  i_ctl,
    output pcc_pkg::t_lane_stat o_stat,
    input  logic [WA-1:0]       i_u,
    input  logic [WB-1:0]       i_v,
    input  logic [WA-1:0]       i_w,
    input  logic [WB-1:0]       i_w2,
    output logic [PW-1:0]       o_res
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_MP   = 4'b0010,
        L_MQ   = 4'b0100,
        L_DONE = 4'b1000
    } t_lane_state;

    t_lane_state        r_state;
    t_lane_state        n_state;
    logic [WA-1:0]      r_w;
    logic [WB-1:0]      r_w2;
    logic [PW-1:0]      r_p;
    logic [PW-1:0]      r_res;
    logic               mul_start;
    logic [WA-1:0]      mul_a;
    logic [WB-1:0]      mul_b;
    logic               mul_done;
    logic [WA+WB-1:0]   mul_p;
    logic [PW:0]        diff;

    pcc_mul #(.WA(WA), .WB(WB)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = i_u;
        mul_b     = i_v;
        case (r_state)
            L_IDLE: begin
                if (i_ctl.start) begin
                    mul_start = 1'b1;
                    n_state   = L_MP;
                end
            end
            L_MP: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = r_w;
                    mul_b     = r_w2;
                    n_state   = L_MQ;
                end
            end
            L_MQ: begin
                if (mul_done) begin
                    n_state = L_DONE;
                end
            end
            L_DONE: begin
                if (i_ctl.take) begin
                    n_state = L_IDLE;
                end
            end
            default: n_state = L_IDLE;
        endcase
    end

    // The top bit is the borrow: set when the second product is the larger one.
    assign diff = {1'b0, r_p} - {1'b0, mul_p[PW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_ctl.start) begin
            r_w  <= i_w;
            r_w2 <= i_w2;
        end
        if (r_state == L_MP && mul_done) begin
            r_p <= mul_p[PW-1:0];
        end
        if (r_state == L_MQ && mul_done) begin
            r_res <= diff[PW] ? '0 : diff[PW-1:0];
        end
    end

    assign o_stat.idle = (r_state == L_IDLE);
    assign o_stat.done = (r_state == L_DONE);
    assign o_res       = r_res;

endmodule

FILE: src/pcc_merge.sv
// Merging stage: degenerate check and the exact squared-correlation compare.
module pcc_merge #(
    parameter int PW = pcc_pkg::MUL_DIGIT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [PW-1:0]                 i_num,
    input  logic [PW-1:0]                 i_va,
    input  logic [PW-1:0]                 i_vb,
    input  logic [pcc_pkg::THR_BITS-1:0]  i_thr,
    output logic                          o_idle,
    pcc_out_if.source                     o_out
);

    localparam int T2W = 2 * pcc_pkg::THR_BITS;
    localparam int WA  = T2W + PW;
    localparam int WB  = PW;
    localparam int LW  = WA + WB;

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_SQR  = 5'b00010,
        M_TA   = 5'b00100,
        M_TAB  = 5'b01000,
        M_OUT  = 5'b10000
    } t_merge_state;

    t_merge_state   r_state;
    t_merge_state   n_state;
    logic [PW-1:0]  r_va;
    logic [PW-1:0]  r_vb;
    logic [T2W-1:0] r_t2;
    logic [LW-1:0]  r_lhs;
    logic           r_linked;
    logic           r_degen;
    logic           flat;
    logic           skip;
    logic           mul_start;
    logic [WA-1:0]  mul_a;
    logic [WB-1:0]  mul_b;
    logic           mul_done;
    logic [LW-1:0]  mul_p;

    pcc_mul #(.WA(WA), .WB(WB)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    // A zero variance ends the test at once; so does a non-positive numerator.
    assign flat = (i_va == '0) || (i_vb == '0);
    assign skip = flat || (i_num == '0);

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = WA'(i_num);
        mul_b     = i_num;
        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    if (skip) begin
                        n_state = M_OUT;
                    end else begin
                        mul_start = 1'b1;
                        n_state   = M_SQR;
                    end
                end
            end
            M_SQR: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = WA'(r_t2);
                    mul_b     = r_va;
                    n_state   = M_TA;
                end
            end
            M_TA: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = mul_p[WA-1:0];
                    mul_b     = r_vb;
                    n_state   = M_TAB;
                end
            end
            M_TAB: begin
                if (mul_done) begin
                    n_state = M_OUT;
                end
            end
            M_OUT: begin
                if (o_out.ready) begin
                    n_state = M_IDLE;
                end
            end
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == M_IDLE && i_start) begin
            r_va     <= i_va;
            r_vb     <= i_vb;
            r_t2     <= T2W'(i_thr) * T2W'(i_thr);
            r_degen  <= flat;
            r_linked <= 1'b0;
        end
        if (r_state == M_SQR && mul_done) begin
            r_lhs <= {mul_p[2*PW-1:0], {T2W{1'b0}}};
        end
        if (r_state == M_TAB && mul_done) begin
            r_linked <= (r_lhs > mul_p);
        end
    end

    assign o_idle           = (r_state == M_IDLE);
    assign o_out.valid      = (r_state == M_OUT);
    assign o_out.linked     = r_linked;
    assign o_out.degenerate = r_degen;

    // A flat vector can never be reported as linked.
    a_degen_unlinked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.linked && o_out.degenerate))
        else $error("result flagged both linked and degenerate");

endmodule

FILE: src/pearson_correlation_threshold_core.sv
// Top level of the Pearson correlation threshold detector.
// Paired samples x and y stream in one beat per cycle while ready is high; each beat updates
// the element count and the sums of x, y, x squared, y squared and x times y after a registered
// product stage, and once MAX_LENGTH pairs have been summed further pairs are ignored until the
// beat marked last. On the last beat the sums are copied into a snapshot and cleared, so the
// next vector streams in at full rate while three parallel lanes form the numerator and both
// variances and a merging stage decides whether num > 0 and num^2 * 2^32 > threshold^2 * A * B;
// that test answers with one result beat carrying linked and degenerate (zero variance, never
// linked). Each lane and the merge stage use one iterative multiplier that forms one 32 by 32
// bit partial product per cycle, so the length of the test grows with the digit pairs of the
// operands (2 in the lanes and 6 in the merge stage at the default parameters). A zero variance
// or a non-positive numerator skips the merge products and answers sooner. The merge stage takes
// a new vector only when it is idle, and a last beat that arrives while the snapshot still
// waits for the lanes is held off with ready low, so vectors that stream in faster than a test
// finishes slow the input to one vector per full test. A threshold write takes effect at once
// and is meant for times when no vector is in flight; there is no clearing pass after reset.
module pearson_correlation_threshold_core #(
    parameter int MAX_LENGTH  = pcc_pkg::MAX_LENGTH_DEF,
    parameter int SAMPLE_BITS = pcc_pkg::SAMPLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcc_in_if.sink     i_in,
    pcc_cfg_if.sink    i_cfg,
    pcc_out_if.source  o_out
);

    // Samples are masked to SAMPLE_BITS, but never to more than the field width of the port.
    localparam int SW = (SAMPLE_BITS < pcc_pkg::FIELD_BITS) ? SAMPLE_BITS : pcc_pkg::FIELD_BITS;
    localparam int CW        = $clog2(MAX_LENGTH + 1);
    localparam int PRW       = 2 * SW;
    localparam int SUMW      = SW + CW;
    localparam int SQW       = PRW + CW;
    localparam int PW        = PRW + 2 * CW;
    localparam int NUM_LANES = 3;
    localparam int LANE_NUM  = 0;
    localparam int LANE_VA   = 1;
    localparam int LANE_VB   = 2;

    // Threshold register.
    logic [pcc_pkg::THR_BITS-1:0] r_thr;

    // Product stage.
    logic           r_s1_valid;
    logic           r_s1_last;
    logic [SW-1:0]  r_s1_x;
    logic [SW-1:0]  r_s1_y;
    logic [PRW-1:0] r_s1_xx;
    logic [PRW-1:0] r_s1_yy;
    logic [PRW-1:0] r_s1_xy;

    // Running sums and their next values.
    logic [CW-1:0]   r_cnt,  n_cnt;
    logic [SUMW-1:0] r_sx,   n_sx;
    logic [SUMW-1:0] r_sy,   n_sy;
    logic [SQW-1:0]  r_sxx,  n_sxx;
    logic [SQW-1:0]  r_syy,  n_syy;
    logic [SQW-1:0]  r_sxy,  n_sxy;

    // Snapshot of a finished vector, waiting for the lanes.
    logic            r_snap_valid;
    logic [CW-1:0]   r_snap_n;
    logic [SUMW-1:0] r_snap_sx;
    logic [SUMW-1:0] r_snap_sy;
    logic [SQW-1:0]  r_snap_sxx;
    logic [SQW-1:0]  r_snap_syy;
    logic [SQW-1:0]  r_snap_sxy;

    logic                        s1_fire;
    logic                        lane_go;
    logic                        merge_go;
    logic                        merge_idle;
    logic [NUM_LANES-1:0]        lane_idle;
    logic [NUM_LANES-1:0]        lane_done;
    pcc_pkg::t_lane_ctl          lane_ctl;
    pcc_pkg::t_lane_stat [NUM_LANES-1:0] lane_stat;
    logic [NUM_LANES-1:0][SUMW-1:0] lane_u;
    logic [NUM_LANES-1:0][SQW-1:0]  lane_v;
    logic [NUM_LANES-1:0][SUMW-1:0] lane_w;
    logic [NUM_LANES-1:0][SQW-1:0]  lane_w2;
    logic [NUM_LANES-1:0][PW-1:0]   lane_res;

    // The configuration port never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= pcc_pkg::THR_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_thr <= i_cfg.threshold_q16;
        end
    end

    // The only stall: a last beat sits in the product stage while the snapshot is still full.
    assign i_in.ready = !(r_s1_valid && r_s1_last && r_snap_valid);
    assign s1_fire    = r_s1_valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_s1_last <= i_in.last;
            r_s1_x    <= i_in.x_sample[SW-1:0];
            r_s1_y    <= i_in.y_sample[SW-1:0];
            r_s1_xx   <= PRW'(i_in.x_sample[SW-1:0]) * PRW'(i_in.x_sample[SW-1:0]);
            r_s1_yy   <= PRW'(i_in.y_sample[SW-1:0]) * PRW'(i_in.y_sample[SW-1:0]);
            r_s1_xy   <= PRW'(i_in.x_sample[SW-1:0]) * PRW'(i_in.y_sample[SW-1:0]);
        end
    end

    // Sums after the pair in the product stage; a full vector ignores the pair.
    always_comb begin
        n_cnt = r_cnt;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_sxx = r_sxx;
        n_syy = r_syy;
        n_sxy = r_sxy;
        if (r_cnt < CW'(MAX_LENGTH)) begin
            n_cnt = r_cnt + 1'b1;
            n_sx  = r_sx + SUMW'(r_s1_x);
            n_sy  = r_sy + SUMW'(r_s1_y);
            n_sxx = r_sxx + SQW'(r_s1_xx);
            n_syy = r_syy + SQW'(r_s1_yy);
            n_sxy = r_sxy + SQW'(r_s1_xy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
        end else if (s1_fire) begin
            if (r_s1_last) begin
                r_cnt <= '0;
                r_sx  <= '0;
                r_sy  <= '0;
                r_sxx <= '0;
                r_syy <= '0;
                r_sxy <= '0;
            end else begin
                r_cnt <= n_cnt;
                r_sx  <= n_sx;
                r_sy  <= n_sy;
                r_sxx <= n_sxx;
                r_syy <= n_syy;
                r_sxy <= n_sxy;
            end
        end
    end

    // The snapshot fills on a last beat and empties when the lanes pick it up. Both cannot
    // happen in one cycle, because a last beat only moves while the snapshot is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (s1_fire && r_s1_last) begin
            r_snap_valid <= 1'b1;
        end else if (lane_go) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            r_snap_n   <= n_cnt;
            r_snap_sx  <= n_sx;
            r_snap_sy  <= n_sy;
            r_snap_sxx <= n_sxx;
            r_snap_syy <= n_syy;
            r_snap_sxy <= n_sxy;
        end
    end

    // Lane operands: the numerator and the two variances all take the form n*S - a*b.
    assign lane_u[LANE_NUM]  = SUMW'(r_snap_n);
    assign lane_v[LANE_NUM]  = r_snap_sxy;
    assign lane_w[LANE_NUM]  = r_snap_sx;
    assign lane_w2[LANE_NUM] = SQW'(r_snap_sy);

    assign lane_u[LANE_VA]   = SUMW'(r_snap_n);
    assign lane_v[LANE_VA]   = r_snap_sxx;
    assign lane_w[LANE_VA]   = r_snap_sx;
    assign lane_w2[LANE_VA]  = SQW'(r_snap_sx);

    assign lane_u[LANE_VB]   = SUMW'(r_snap_n);
    assign lane_v[LANE_VB]   = r_snap_syy;
    assign lane_w[LANE_VB]   = r_snap_sy;
    assign lane_w2[LANE_VB]  = SQW'(r_snap_sy);

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            lane_idle[l] = lane_stat[l].idle;
            lane_done[l] = lane_stat[l].done;
        end
    end

    assign lane_go        = r_snap_valid && (&lane_idle);
    assign merge_go       = (&lane_done) && merge_idle;
    assign lane_ctl.start = lane_go;
    assign lane_ctl.take  = merge_go;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        pcc_lane #(.WA(SUMW), .WB(SQW), .PW(PW)) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .o_stat  (lane_stat[g]),
            .i_u     (lane_u[g]),
            .i_v     (lane_v[g]),
            .i_w     (lane_w[g]),
            .i_w2    (lane_w2[g]),
            .o_res   (lane_res[g])
        );
    end

    pcc_merge #(.PW(PW)) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (merge_go),
        .i_num   (lane_res[LANE_NUM]),
        .i_va    (lane_res[LANE_VA]),
        .i_vb    (lane_res[LANE_VB]),
        .i_thr   (r_thr),
        .o_idle  (merge_idle),
        .o_out   (o_out)
    );

    // The element count saturates at the vector length limit.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_LENGTH))
        else $error("element count beyond the length limit");

    // All lanes get the same operand widths, so they must finish in the same cycle.
    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lane_done[LANE_NUM] == lane_done[LANE_VA]) &&
        (lane_done[LANE_NUM] == lane_done[LANE_VB]))
        else $error("lanes out of step");

    // Once picked up, the snapshot must be free in the next cycle.
    a_snap_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_go |=> !r_snap_valid)
        else $error("snapshot still held after lane start");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the Pearson correlation threshold detector.

typedef struct packed {
    logic linked;
    logic degenerate;
} t_verdict;

// Keeps its own copy of the sums and the threshold, predicts the verdict of each vector when
// its last beat is accepted, and compares every result beat with the oldest prediction.
class corr_scoreboard;
    localparam int MAX_LEN = pcc_pkg::MAX_LENGTH_DEF;
    localparam logic [pcc_pkg::FIELD_BITS-1:0] SAMPLE_MASK =
        16'((1 << pcc_pkg::SAMPLE_BITS_DEF) - 1);

    logic [pcc_pkg::THR_BITS-1:0] threshold;
    logic [10:0]                  count;
    logic [25:0]                  sum_x;
    logic [25:0]                  sum_y;
    logic [41:0]                  sum_xx;
    logic [41:0]                  sum_yy;
    logic [41:0]                  sum_xy;
    t_verdict                     expected_verdicts[$];
    int                           errors;

    function new();
        threshold = pcc_pkg::THR_RESET;
        errors    = 0;
        clear_sums();
    endfunction

    function void clear_sums();
        count  = '0;
        sum_x  = '0;
        sum_y  = '0;
        sum_xx = '0;
        sum_yy = '0;
        sum_xy = '0;
    endfunction

    function void set_threshold(logic [pcc_pkg::THR_BITS-1:0] thr);
        threshold = thr;
    endfunction

    function int outstanding();
        return expected_verdicts.size();
    endfunction

    // u*v - w*z, clipped at zero, in a width that holds every product exactly.
    function logic [255:0] clipped_diff(logic [255:0] u, logic [255:0] v,
                                        logic [255:0] w, logic [255:0] z);
        logic [255:0] p;
        logic [255:0] q;
        p = u * v;
        q = w * z;
        return (p > q) ? p - q : '0;
    endfunction

    // Exact integer form of num / sqrt(A*B) > threshold / 2^16.
    function t_verdict judge_vectors();
        logic [255:0] num;
        logic [255:0] var_x;
        logic [255:0] var_y;
        logic [255:0] thr;
        logic [255:0] lhs;
        logic [255:0] rhs;
        t_verdict     v;
        num   = clipped_diff(256'(count), 256'(sum_xy), 256'(sum_x), 256'(sum_y));
        var_x = clipped_diff(256'(count), 256'(sum_xx), 256'(sum_x), 256'(sum_x));
        var_y = clipped_diff(256'(count), 256'(sum_yy), 256'(sum_y), 256'(sum_y));
        thr   = 256'(threshold);
        v     = '0;
        if (var_x == 0 || var_y == 0) begin
            v.degenerate = 1'b1;
        end else if (num != 0) begin
            lhs = (num * num) << 32;
            rhs = thr * thr * var_x * var_y;
            v.linked = (lhs > rhs);
        end
        return v;
    endfunction

    function void note_pair(logic [pcc_pkg::FIELD_BITS-1:0] x_raw,
                            logic [pcc_pkg::FIELD_BITS-1:0] y_raw, logic last);
        logic [pcc_pkg::FIELD_BITS-1:0] x;
        logic [pcc_pkg::FIELD_BITS-1:0] y;
        x = x_raw & SAMPLE_MASK;
        y = y_raw & SAMPLE_MASK;
        // Pairs past the length limit are dropped, but a last flag still closes the vector.
        if (count < MAX_LEN) begin
            count  = count + 1'b1;
            sum_x  = sum_x + 26'(x);
            sum_y  = sum_y + 26'(y);
            sum_xx = sum_xx + 42'(x) * 42'(x);
            sum_yy = sum_yy + 42'(y) * 42'(y);
            sum_xy = sum_xy + 42'(x) * 42'(y);
        end
        if (last) begin
            expected_verdicts.push_back(judge_vectors());
            clear_sums();
        end
    endfunction

    function void check_verdict(logic linked, logic degenerate);
        t_verdict want;
        if (expected_verdicts.size() == 0) begin
            $display("%0t: result beat with no verdict pending, got linked=%b degenerate=%b",
                     $time, linked, degenerate);
            errors++;
            return;
        end
        want = expected_verdicts.pop_front();
        if (linked !== want.linked) begin
            $display("%0t: linked mismatch, expected %b, got %b", $time, want.linked, linked);
            errors++;
        end
        if (degenerate !== want.degenerate) begin
            $display("%0t: degenerate mismatch, expected %b, got %b",
                     $time, want.degenerate, degenerate);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int MAX_LEN        = pcc_pkg::MAX_LENGTH_DEF;
    localparam int FB             = pcc_pkg::FIELD_BITS;
    // Quiet cycles after a phase and at the end.
    localparam int SETTLE_CYCLES  = 100;
    localparam int TAIL_CYCLES    = 200;
    // No beat on any channel for this long means the block has hung.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 45;
    localparam int RANDOM_PHASES  = 7;

    // How the pairs of one random vector relate to each other.
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_SCALED,
        SHAPE_FLAT_X,
        SHAPE_FLAT_Y,
        SHAPE_EXTREME,
        SHAPE_NEAR_FULL
    } t_pair_shape;

    // Patterns on which the result receiver holds ready low.
    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_SPARSE,
        STALL_LONG
    } t_stall_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pcc_in_if  in_bus ();
    pcc_cfg_if cfg_bus ();
    pcc_out_if verdict_bus ();

    corr_scoreboard sb = new();

    // Sender state shared by the driving tasks.
    int burst_left = 0;
    int items_sent = 0;
    bit steady     = 1'b0;

    pearson_correlation_threshold_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (verdict_bus)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Monitor: every beat is taken at the clock edge where valid and ready are both high.
    // Values are read before the edge's nonblocking updates land, so there is no race.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (verdict_bus.valid && verdict_bus.ready) begin
                sb.check_verdict(verdict_bus.linked, verdict_bus.degenerate);
            end
            if (in_bus.valid && in_bus.ready) begin
                sb.note_pair(in_bus.x_sample, in_bus.y_sample, in_bus.last);
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                sb.set_threshold(cfg_bus.threshold_q16);
            end
        end
    end

    // Result receiver. A stall pattern is drawn at random for each window of steps, and one pattern
    // holds ready low for most of the window, so results pile up behind the block's output.
    initial begin : verdict_receiver
        t_stall_mode mode;
        int          step;
        verdict_bus.ready <= 1'b0;
        mode = STALL_NONE;
        step = 0;
        forever begin
            @(posedge i_clk);
            if (step % 50 == 0) begin
                mode = t_stall_mode'($urandom_range(0, STALL_LONG));
            end
            step++;
            case (mode)
                STALL_NONE:   verdict_bus.ready <= 1'b1;
                STALL_COIN:   verdict_bus.ready <= 1'($urandom_range(0, 1));
                STALL_SPARSE: verdict_bus.ready <= (step % 7 == 0);
                default:      verdict_bus.ready <= (step % 50) > 35;
            endcase
        end
    end

    // Watchdog: a run where nothing moves on any channel for too long has hung.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid && in_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
                (verdict_bus.valid && verdict_bus.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    function automatic logic [FB-1:0] clamp16(int v);
        if (v < 0) begin
            return '0;
        end
        if (v > 65535) begin
            return 16'hFFFF;
        end
        return v[FB-1:0];
    endfunction

    // Offers one pair and waits until it is accepted. The sender runs in bursts; a gap lowers
    // valid only when it is not empty, so valid never drops and rises in one step.
    task automatic send_pair(input logic [FB-1:0] x, input logic [FB-1:0] y, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_bus.valid    <= 1'b1;
        in_bus.x_sample <= x;
        in_bus.y_sample <= y;
        in_bus.last     <= last;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        items_sent++;
    endtask

    // Sends one whole vector of the given shape. Pairs beyond the length limit carry plain
    // noise, so a block that still summed them would most likely change its verdict.
    task automatic send_vector(input int len, input t_pair_shape shape);
        int           amp;
        int           noise;
        int           shift;
        int           d;
        logic [FB-1:0] flat;
        logic [FB-1:0] x;
        logic [FB-1:0] y;
        case ($urandom_range(0, 3))
            0:       amp = 0;
            1:       amp = 4;
            2:       amp = 300;
            default: amp = 6000;
        endcase
        shift = $urandom_range(0, 8);
        flat  = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        for (int i = 0; i < len; i++) begin
            noise = $urandom_range(0, 2 * amp) - amp;
            x     = 16'($urandom_range(0, 65535));
            y     = 16'($urandom_range(0, 65535));
            if (i < MAX_LEN) begin
                case (shape)
                    SHAPE_RISING:  y = clamp16(int'(x) + noise);
                    SHAPE_FALLING: y = clamp16(65535 - int'(x) + noise);
                    SHAPE_SCALED:  y = clamp16(int'(x >> shift) + noise);
                    SHAPE_FLAT_X:  x = flat;
                    SHAPE_FLAT_Y:  y = flat;
                    SHAPE_EXTREME: begin
                        x = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
                        y = ($urandom_range(0, 3) == 0) ? ~x : x;
                    end
                    SHAPE_NEAR_FULL: begin
                        d = $urandom_range(0, 1023);
                        x = 16'(65535 - d);
                        y = clamp16(int'(x) + noise);
                    end
                    default: ;
                endcase
            end
            send_pair(x, y, i == len - 1);
        end
    endtask

    // Lets the block run dry: every predicted verdict back, then a quiet spell for any pairs
    // that are still in the accumulator pipeline.
    task automatic finish_phase();
        in_bus.valid <= 1'b0;
        burst_left = 0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [pcc_pkg::THR_BITS-1:0] thr);
        cfg_bus.valid         <= 1'b1;
        cfg_bus.threshold_q16 <= thr;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [pcc_pkg::THR_BITS-1:0] thr;
        int                           len;
        int                           pick;
        int                           phase_start;

        in_bus.valid          <= 1'b0;
        in_bus.x_sample       <= '0;
        in_bus.y_sample       <= '0;
        in_bus.last           <= 1'b0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.threshold_q16 <= '0;
        i_rst_n               <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed vectors at the threshold left by reset (0.9).
        // A single pair has no variance at all.
        send_pair(16'h0000, 16'h0000, 1'b1);
        // Nearly perfect positive correlation across the full sample range.
        send_pair(16'h0000, 16'h0000, 1'b0);
        send_pair(16'hFFFF, 16'hFFFF, 1'b0);
        send_pair(16'd30000, 16'd30001, 1'b1);
        // Negative correlation gives a negative numerator: never linked.
        send_pair(16'h0000, 16'hFFFF, 1'b0);
        send_pair(16'hFFFF, 16'h0000, 1'b0);
        send_pair(16'd1000, 16'd64535, 1'b1);
        // A constant first vector has zero variance.
        send_pair(16'd5, 16'd1, 1'b0);
        send_pair(16'd5, 16'd2, 1'b0);
        send_pair(16'd5, 16'd3, 1'b1);
        // A constant second vector at the top of the range.
        send_pair(16'd1, 16'hFFFF, 1'b0);
        send_pair(16'd2, 16'hFFFF, 1'b1);
        // Alternating bit patterns, anti-correlated.
        send_pair(16'hAAAA, 16'h5555, 1'b0);
        send_pair(16'h5555, 16'hAAAA, 1'b1);
        finish_phase();

        // Zero threshold: any positive numerator with nonzero variances links.
        write_threshold('0);
        send_pair(16'd1, 16'd1, 1'b0);
        send_pair(16'd2, 16'd3, 1'b0);
        send_pair(16'd3, 16'd2, 1'b1);
        // Numerator exactly zero: not linked and not degenerate.
        send_pair(16'd1, 16'd1, 1'b0);
        send_pair(16'd2, 16'd2, 1'b0);
        send_pair(16'd3, 16'd1, 1'b1);
        finish_phase();

        // Largest threshold: only an exact straight line beats it.
        write_threshold(16'hFFFF);
        send_pair(16'h0000, 16'h0000, 1'b0);
        send_pair(16'hFFFF, 16'hFFFF, 1'b1);
        finish_phase();

        // One vector longer than the length limit, with samples near full scale so the sums
        // come close to their widest values.
        write_threshold(16'($urandom_range(50000, 65000)));
        steady = 1'b0;
        send_vector(MAX_LEN + 3, SHAPE_NEAR_FULL);
        finish_phase();

        // Random phases of short vectors, each under a threshold of its own. Every phase ends
        // with the sender holding off until all verdicts are back.
        for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
            case (phase)
                1:       thr = 16'hFFFF;
                2:       thr = '0;
                3:       thr = pcc_pkg::THR_RESET;
                4:       thr = 16'h8000;
                default: thr = 16'($urandom_range(40000, 65535));
            endcase
            write_threshold(thr);
            steady      = ($urandom_range(0, 3) == 0);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    len = 1;
                end else if (pick < 85) begin
                    len = $urandom_range(2, 8);
                end else begin
                    len = $urandom_range(9, 24);
                end
                send_vector(len, t_pair_shape'($urandom_range(0, SHAPE_NEAR_FULL)));
            end
            finish_phase();
        end

        in_bus.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
